[rtl/core/gcl_pkg.sv]
// Shared constants, types and sequencer states of the gcd and lcm unit.
package gcl_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
  // Two guard bits: one for the shifted-in dividend bit, one for the sign.
  localparam int ALU_WIDTH     = OPERAND_WIDTH + 2;
  localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [PRODUCT_WIDTH-1:0] product_t;
  typedef logic [ALU_WIDTH-1:0]     alu_word_t;
  typedef logic [COUNT_WIDTH-1:0]   count_t;

  localparam count_t LAST_STEP = COUNT_WIDTH'(OPERAND_WIDTH - 1);

  typedef struct packed {
    alu_word_t op_a;
    alu_word_t op_b;
    logic      subtract;
  } alu_req_t;

  typedef struct packed {
    operand_t common_divisor;
    product_t common_multiple;
    logic     operand_error;
  } result_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GCD   = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

[rtl/core/gcl_if.sv]
// Valid/ready channel interfaces for the operand items and the result items.
interface gcl_in_if import gcl_pkg::*;;
  logic     valid;
  logic     ready;
  operand_t first_operand;
  operand_t second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface gcl_out_if import gcl_pkg::*;;
  logic     valid;
  logic     ready;
  operand_t common_divisor;
  product_t common_multiple;
  logic     operand_error;

  modport source (output valid, output common_divisor, output common_multiple,
                  output operand_error, input ready);
  modport sink   (input valid, input common_divisor, input common_multiple,
                  input operand_error, output ready);
endinterface

[rtl/core/gcl_alu.sv]
// Shared adder/subtractor used by the gcd, divide and multiply phases of the sequencer.
module gcl_alu import gcl_pkg::*; (
  input  alu_req_t  req,
  output alu_word_t res
);

  // Subtraction as a + ~b + 1; the top bit is the sign for zero-extended operands.
  assign res = req.op_a + (req.subtract ? ~req.op_b : req.op_b) + ALU_WIDTH'(req.subtract);

endmodule

[rtl/core/gcl_seq.sv]
// Sequencer and working registers: binary gcd, exact division, shift-add multiply.
module gcl_seq import gcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start_valid,
  output logic      start_ready,
  input  operand_t  first_operand,
  input  operand_t  second_operand,
  output alu_req_t  alu_req,
  input  alu_word_t alu_res,
  output logic      res_valid,
  output result_t   res,
  input  logic      res_take
);

  state_t   state_r, state_nxt;
  operand_t x_r, x_nxt;     // gcd working value, then the divisor g
  operand_t y_r, y_nxt;     // gcd working value, then remainder, then product high half
  operand_t a_r, a_nxt;     // dividend/quotient, then product low half
  operand_t b_r, b_nxt;     // second operand kept for the multiply
  count_t   k_r, k_nxt;     // common factors of two removed
  count_t   cnt_r, cnt_nxt;
  logic     err_r, err_nxt;

  logic     zero_op;
  logic     neg;
  logic     diff_zero;

  assign zero_op   = (first_operand == '0) || (second_operand == '0);
  assign neg       = alu_res[ALU_WIDTH-1];
  assign diff_zero = (alu_res == '0);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    alu_req   = '{op_a: '0, op_b: '0, subtract: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (start_valid) begin
          err_nxt   = zero_op;
          x_nxt     = zero_op ? '0 : first_operand;
          y_nxt     = zero_op ? '0 : second_operand;
          a_nxt     = zero_op ? '0 : first_operand;
          b_nxt     = second_operand;
          k_nxt     = '0;
          state_nxt = zero_op ? ST_DONE : ST_GCD;
        end
      end
      ST_GCD: begin
        alu_req = '{op_a: ALU_WIDTH'(x_r), op_b: ALU_WIDTH'(y_r), subtract: 1'b1};
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (diff_zero) begin
          state_nxt = ST_SHIFT;
        end else if (neg) begin
          // Keep the larger value in x so the next difference is positive.
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = alu_res[OPERAND_WIDTH:1];
        end
      end
      ST_SHIFT: begin
        if (k_r == '0) begin
          y_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          x_nxt = x_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      ST_DIV: begin
        alu_req = '{op_a: ALU_WIDTH'({y_r, a_r[OPERAND_WIDTH-1]}),
                    op_b: ALU_WIDTH'(x_r), subtract: 1'b1};
        if (!neg) begin
          y_nxt = alu_res[OPERAND_WIDTH-1:0];
          a_nxt = {a_r[OPERAND_WIDTH-2:0], 1'b1};
        end else begin
          y_nxt = {y_r[OPERAND_WIDTH-2:0], a_r[OPERAND_WIDTH-1]};
          a_nxt = {a_r[OPERAND_WIDTH-2:0], 1'b0};
        end
        if (cnt_r == LAST_STEP) begin
          // The division is exact, so the remainder is dropped and the
          // register starts over as the product's high half.
          y_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        alu_req = '{op_a: ALU_WIDTH'(y_r),
                    op_b: a_r[0] ? ALU_WIDTH'(b_r) : '0, subtract: 1'b0};
        y_nxt = alu_res[OPERAND_WIDTH:1];
        a_nxt = {alu_res[0], a_r[OPERAND_WIDTH-1:1]};
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    err_r <= err_nxt;
  end

  assign start_ready         = (state_r == ST_IDLE);
  assign res_valid           = (state_r == ST_DONE);
  assign res.common_divisor  = x_r;
  assign res.common_multiple = {y_r, a_r};
  assign res.operand_error   = err_r;

endmodule

[rtl/core/gcd_lcm_unit.sv]
// Top level of the gcd and lcm unit: sequencer, shared adder and output register.
//
// The operand channel in_chan carries two unsigned operands per item; the
// result channel out_chan returns one item holding their greatest common
// divisor, least common multiple and an error flag. Both channels use a
// valid/ready handshake and move an item at a clock edge where both are high.
// An item with a zero operand sets operand_error and returns zeros.
// Otherwise the sequencer runs the binary gcd (one step a cycle), shifts
// the common power of two back in, divides the first operand by the gcd
// and multiplies the quotient by the second operand, all on one shared
// adder/subtractor. One item is worked on at a time.
// The result goes to an output register, so the next item is taken while the
// previous result still waits; a stalled receiver holds that register and,
// once the next result is ready too, the sequencer waits with it.
// The synchronous active-low reset returns the sequencer to idle and empties
// the output register; no other state is kept between items.
module gcd_lcm_unit import gcl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  gcl_in_if.sink       in_chan,
  gcl_out_if.source    out_chan
);

  alu_req_t  alu_req;
  alu_word_t alu_res;
  logic      res_valid;
  logic      res_take;
  result_t   res;

  logic      out_valid_r;
  result_t   out_data_r;

  gcl_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  gcl_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_valid    (in_chan.valid),
    .start_ready    (in_chan.ready),
    .first_operand  (in_chan.first_operand),
    .second_operand (in_chan.second_operand),
    .alu_req        (alu_req),
    .alu_res        (alu_res),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take)
  );

  // The finished result moves into the output register whenever that
  // register is empty or is being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.common_divisor  = out_data_r.common_divisor;
  assign out_chan.common_multiple = out_data_r.common_multiple;
  assign out_chan.operand_error   = out_data_r.operand_error;

endmodule

[verif/gcl_result_checker.sv]
// Result checker for the gcd and lcm unit: predicts each result and compares it.
`timescale 1ns / 100ps

module gcl_result_checker import gcl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gcl_in_if    in_chan,
  gcl_out_if   out_chan,
  output int   mismatch_count,
  output int   awaited_count
);

  result_t awaited_results[$];
  int      mismatches = 0;

  // Euclid on the operand width; the lcm is formed as (a / gcd) * b, which always fits.
  function automatic result_t predict_gcd_lcm(operand_t a, operand_t b);
    result_t  r;
    operand_t x;
    operand_t y;
    operand_t rem;
    if (a == '0 || b == '0) begin
      r.common_divisor  = '0;
      r.common_multiple = '0;
      r.operand_error   = 1'b1;
      return r;
    end
    x = a;
    y = b;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    r.common_divisor  = x;
    r.common_multiple = product_t'(a / x) * product_t'(b);
    r.operand_error   = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      // The result register decouples the two sides, so pop before push.
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no expectation waiting: gcd %0d lcm %0d err %0b",
                 out_chan.common_divisor, out_chan.common_multiple, out_chan.operand_error);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_chan.common_divisor !== want.common_divisor) begin
            $error("common_divisor: expected %0d, got %0d",
                   want.common_divisor, out_chan.common_divisor);
            mismatches++;
          end
          if (out_chan.common_multiple !== want.common_multiple) begin
            $error("common_multiple: expected %0d, got %0d",
                   want.common_multiple, out_chan.common_multiple);
            mismatches++;
          end
          if (out_chan.operand_error !== want.operand_error) begin
            $error("operand_error: expected %0b, got %0b",
                   want.operand_error, out_chan.operand_error);
            mismatches++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        awaited_results.push_back(predict_gcd_lcm(in_chan.first_operand,
                                                  in_chan.second_operand));
      end
    end
    mismatch_count <= mismatches;
    awaited_count  <= awaited_results.size();
  end

endmodule

[verif/tb_gcd_lcm_unit.sv]
// Testbench top of the gcd and lcm unit: clock, reset, operand stimulus and verdict.
`timescale 1ns / 100ps

module tb_gcd_lcm_unit;
  import gcl_pkg::*;

  // The slowest correct run is some 1500 items plus source gaps; this limit
  // leaves ample margin.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1500;
  // Items in this window are sent and drained with no idling on either side.
  localparam int CALM_FIRST    = 600;
  localparam int CALM_LAST     = 899;
  // A little more than the longest item, so that a stray late result is seen.
  localparam int DRAIN_CYCLES  = 120;

  logic clk;
  logic rst_n;
  logic calm;
  int   cycle_count;
  int   mismatch_count;
  int   awaited_count;

  gcl_in_if  op_chan ();
  gcl_out_if res_chan ();

  gcd_lcm_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_chan),
    .out_chan (res_chan)
  );

  gcl_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (op_chan),
    .out_chan       (res_chan),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung block must still end the run with a verdict.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // The result receiver stalls about a quarter of the time, except during
  // the calm window where it always takes the result at once.
  initial begin
    res_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_chan.ready <= rst_n && (calm || $urandom_range(0, 99) >= 26);
    end
  end

  // Offers one item, with random idle cycles ahead of it, and returns at the
  // clock edge where the block takes it. Valid stays high into the next item
  // when no idle cycle is drawn, so back-to-back items are exercised too.
  task automatic send_operands(input operand_t a, input operand_t b);
    while (!calm && $urandom_range(0, 99) < 26) begin
      op_chan.valid <= 1'b0;
      @(posedge clk);
    end
    op_chan.valid          <= 1'b1;
    op_chan.first_operand  <= a;
    op_chan.second_operand <= b;
    @(posedge clk);
    while (!op_chan.ready) @(posedge clk);
  endtask

  initial begin
    operand_t a;
    operand_t b;
    operand_t g;
    int       pick;

    calm                   = 1'b0;
    rst_n                 <= 1'b0;
    op_chan.valid         <= 1'b0;
    op_chan.first_operand  <= '0;
    op_chan.second_operand <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items. Zero operands on each side and on both raise the error flag.
    send_operands(16'd0, 16'd0);
    send_operands(16'd0, 16'd1234);
    send_operands(16'hFFFF, 16'd0);
    // Equal operands: the gcd and the lcm both equal the operand.
    send_operands(16'd1, 16'd1);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'h8000, 16'h8000);
    // One operand dividing the other, in both orders.
    send_operands(16'hFFFF, 16'd1);
    send_operands(16'd1, 16'hFFFF);
    send_operands(16'h8000, 16'h4000);
    send_operands(16'h0100, 16'h8000);
    send_operands(16'd21845, 16'hFFFF);
    // Coprime neighbours near the top give the largest multiples.
    send_operands(16'hFFFF, 16'hFFFE);
    send_operands(16'hFFFE, 16'hFFFF);
    send_operands(16'd65521, 16'd65519);
    // Alternating bit patterns and mixed powers of two.
    send_operands(16'h5555, 16'hAAAA);
    send_operands(16'hAAAA, 16'h5555);
    send_operands(16'd1024, 16'd768);
    send_operands(16'd48, 16'd36);
    send_operands(16'd12, 16'd18);
    send_operands(16'd7, 16'd13);
    send_operands(16'h7FFF, 16'h8001);

    // Random items, mostly well formed with a spread of shapes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FIRST && i <= CALM_LAST);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Full-range operands, usually with a small gcd.
        a = operand_t'($urandom_range(1, 16'hFFFF));
        b = operand_t'($urandom_range(1, 16'hFFFF));
      end else if (pick < 55) begin
        // A built-in common factor, so the gcd is large and varied.
        g = operand_t'($urandom_range(1, 4095));
        a = g * operand_t'($urandom_range(1, 16'hFFFF / g));
        b = g * operand_t'($urandom_range(1, 16'hFFFF / g));
      end else if (pick < 70) begin
        // Small operands.
        a = operand_t'($urandom_range(1, 255));
        b = operand_t'($urandom_range(1, 255));
      end else if (pick < 82) begin
        // Shared powers of two stress the shift-back stage.
        a = operand_t'($urandom_range(1, 16'hFFFF)) << $urandom_range(0, 15);
        b = operand_t'($urandom_range(1, 16'hFFFF)) << $urandom_range(0, 15);
        if (a == '0) a = 16'h8000;
        if (b == '0) b = 16'h8000;
      end else if (pick < 90) begin
        // One operand a multiple of the other, or equal to it.
        a = operand_t'($urandom_range(1, 16'hFFFF));
        b = a * operand_t'($urandom_range(1, 16'hFFFF / a));
        if ($urandom_range(0, 1) == 1) begin
          g = a;
          a = b;
          b = g;
        end
      end else if (pick < 95) begin
        // Zero operand on one side or both.
        a = operand_t'($urandom_range(0, 16'hFFFF));
        b = operand_t'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 2))
          0: a = '0;
          1: b = '0;
          default: begin
            a = '0;
            b = '0;
          end
        endcase
      end else begin
        // Raw bit patterns, zero allowed.
        a = operand_t'($urandom());
        b = operand_t'($urandom());
      end
      send_operands(a, b);
    end

    // Drain: every result must arrive, then nothing further may come.
    // One edge first, so that the count includes the last item taken.
    calm = 1'b0;
    op_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gcl_pkg.sv
rtl/core/gcl_if.sv
rtl/core/gcl_alu.sv
rtl/core/gcl_seq.sv
rtl/core/gcd_lcm_unit.sv
verif/gcl_result_checker.sv
verif/tb_gcd_lcm_unit.sv
